// ----- rtl/core/modbus_rtu_response_checker_top_defines.svh -----
// ----------------------------------------------------------------------------
// Modbus RTU response checker - assertion macros
// Shared assertion shorthands, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_CHECKER_TOP_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define MRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define MRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/mrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, codes and the CRC-16 byte update shared by the response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    // input item modes
    localparam logic [1:0] MODE_ARM  = 2'd0;
    localparam logic [1:0] MODE_BYTE = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    // function codes
    localparam logic [7:0] FC_READ_COILS    = 8'h01;
    localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT    = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
    localparam logic [7:0] FC_WRITE_REG     = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS   = 8'h0f;
    localparam logic [7:0] FC_WRITE_REGS    = 8'h10;

    localparam logic [15:0] COIL_ON_WORD = 16'hff00;
    localparam logic [15:0] CRC_INIT     = 16'hffff;
    localparam logic [15:0] CRC_POLY     = 16'ha001;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CRC_FAIL = 3'd1;
    localparam logic [2:0] ST_HEADER   = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_ARM,
        OP_REJECT,
        OP_BYTE,
        OP_END
    } t_cmd_op;

    // classified item between front and back
    typedef struct packed {
        t_cmd_op     op;
        logic [7:0]  slave;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] word;
        logic [7:0]  length;
        logic [7:0]  data;
    } t_cmd;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_queue_stat;

    typedef struct packed {
        logic active;
        logic pop;
    } t_back_stat;

    // Modbus CRC-16, reflected, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/mrc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_front
// Classifies input items and works out the expected reply length on arm.
// ----------------------------------------------------------------------------
module mrc_front #(
    parameter int MAX_FRAME = 256
) (
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_slave_address,
    input  logic [7:0]  i_function_code,
    input  logic [15:0] i_start_address,
    input  logic [15:0] i_count_or_value,
    input  logic [7:0]  i_data_byte,
    output logic        o_cmd_valid,
    output mrc_pkg::t_cmd o_cmd
);

    localparam int LIMIT = (MAX_FRAME < 255) ? MAX_FRAME : 255;
    localparam logic [17:0] LIMIT_W = 18'(LIMIT);

    logic [17:0] len_coil;
    logic [17:0] len_reg;
    logic [17:0] len_full;
    logic        supported;
    logic [15:0] echo_word;

    assign len_coil = ((18'(i_count_or_value) + 18'd7) >> 3) + 18'd5;
    assign len_reg  = {1'b0, i_count_or_value, 1'b0} + 18'd5;

    always_comb begin
        supported = 1'b1;
        echo_word = i_count_or_value;
        len_full  = 18'd8;
        case (i_function_code)
            mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_DISCRETE: begin
                len_full = len_coil;
            end
            mrc_pkg::FC_READ_HOLDING, mrc_pkg::FC_READ_INPUT: begin
                len_full = len_reg;
            end
            mrc_pkg::FC_WRITE_COIL: begin
                echo_word = i_count_or_value[0] ? mrc_pkg::COIL_ON_WORD : 16'h0000;
            end
            mrc_pkg::FC_WRITE_REG, mrc_pkg::FC_WRITE_COILS, mrc_pkg::FC_WRITE_REGS: begin
                len_full = 18'd8;
            end
            default: begin
                supported = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_cmd.op     = mrc_pkg::OP_BYTE;
        o_cmd.slave  = i_slave_address;
        o_cmd.func   = i_function_code;
        o_cmd.addr   = i_start_address;
        o_cmd.word   = echo_word;
        o_cmd.length = len_full[7:0];
        o_cmd.data   = i_data_byte;
        o_cmd_valid  = 1'b1;
        case (i_mode)
            mrc_pkg::MODE_ARM: begin
                if (!supported || (len_full > LIMIT_W)) begin
                    o_cmd.op = mrc_pkg::OP_REJECT;
                end else begin
                    o_cmd.op = mrc_pkg::OP_ARM;
                end
            end
            mrc_pkg::MODE_BYTE: begin
                o_cmd.op = mrc_pkg::OP_BYTE;
            end
            mrc_pkg::MODE_END: begin
                o_cmd.op = mrc_pkg::OP_END;
            end
            default: begin
                // unused mode: dropped here
                o_cmd_valid = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/mrc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module mrc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mrc_pkg::t_cmd        i_data,
    input  logic                 i_pop,
    output mrc_pkg::t_cmd        o_data,
    output logic                 o_valid,
    output mrc_pkg::t_queue_stat o_stat
);

    mrc_pkg::t_cmd                 r_mem [mrc_pkg::QUEUE_DEPTH];
    logic [mrc_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [mrc_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [mrc_pkg::QCNT_W-1:0]    r_count;
    logic [mrc_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [mrc_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic [mrc_pkg::QCNT_W-1:0]    n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_valid      = (r_count != '0);
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == mrc_pkg::QCNT_W'(mrc_pkg::QUEUE_DEPTH));

endmodule

// ----- rtl/core/mrc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_back
// Runs the reply check: CRC, header and echo compare, payload and status.
// ----------------------------------------------------------------------------
module mrc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  mrc_pkg::t_cmd       i_cmd,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_out_kind,
    output logic [15:0]         o_out_word,
    output logic [2:0]          o_out_status,
    output mrc_pkg::t_back_stat o_stat
);

    logic        r_active;
    logic [7:0]  r_len;
    logic [7:0]  r_count;
    logic [15:0] r_crc;
    logic        r_hbad;
    logic [7:0]  r_held;
    logic [7:0]  r_slave;
    logic [7:0]  r_func;
    logic [15:0] r_addr;
    logic [15:0] r_word;
    logic        r_out_valid;
    logic        r_out_kind;
    logic [15:0] r_out_word;
    logic [2:0]  r_out_status;

    logic        n_active;
    logic [7:0]  n_len;
    logic [7:0]  n_count;
    logic [15:0] n_crc;
    logic        n_hbad;
    logic [7:0]  n_held;
    logic [7:0]  n_slave;
    logic [7:0]  n_func;
    logic [15:0] n_addr;
    logic [15:0] n_word;

    logic        pop;
    logic        res_valid;
    logic        res_kind;
    logic [15:0] res_word;
    logic [2:0]  res_status;
    logic [8:0]  pos2;
    logic        want_en;
    logic [7:0]  want;
    logic        is_read;
    logic        is_coil;
    logic        is_single;
    logic        crc_bad;
    logic [7:0]  b;

    assign pop       = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign b         = i_cmd.data;
    assign pos2      = {1'b0, r_count} + 9'd2;
    assign is_read   = (r_func >= mrc_pkg::FC_READ_COILS) && (r_func <= mrc_pkg::FC_READ_INPUT);
    assign is_coil   = (r_func <= mrc_pkg::FC_READ_DISCRETE);
    assign is_single = (r_func == mrc_pkg::FC_WRITE_COIL) || (r_func == mrc_pkg::FC_WRITE_REG);
    assign crc_bad   = ({b, r_held} != r_crc);

    // expected header or echo byte at the current offset
    always_comb begin
        want_en = 1'b1;
        want    = 8'h00;
        case (r_count)
            8'd0: want = r_slave;
            8'd1: want = r_func;
            8'd2: want = is_read ? (r_len - 8'd5) : r_addr[15:8];
            8'd3: begin
                want    = r_addr[7:0];
                want_en = !is_read;
            end
            8'd4: begin
                want    = r_word[15:8];
                want_en = !is_read;
            end
            8'd5: begin
                want    = r_word[7:0];
                want_en = !is_read;
            end
            default: want_en = 1'b0;
        endcase
    end

    always_comb begin
        n_active   = r_active;
        n_len      = r_len;
        n_count    = r_count;
        n_crc      = r_crc;
        n_hbad     = r_hbad;
        n_held     = r_held;
        n_slave    = r_slave;
        n_func     = r_func;
        n_addr     = r_addr;
        n_word     = r_word;
        res_valid  = 1'b0;
        res_kind   = mrc_pkg::KIND_DATA;
        res_word   = 16'h0000;
        res_status = mrc_pkg::ST_OK;
        if (pop) begin
            case (i_cmd.op)
                mrc_pkg::OP_REJECT: begin
                    n_active   = 1'b0;
                    res_valid  = 1'b1;
                    res_kind   = mrc_pkg::KIND_STATUS;
                    res_status = mrc_pkg::ST_REJECTED;
                end
                mrc_pkg::OP_ARM: begin
                    n_active = 1'b1;
                    n_len    = i_cmd.length;
                    n_count  = 8'd0;
                    n_crc    = mrc_pkg::CRC_INIT;
                    n_hbad   = 1'b0;
                    n_held   = 8'h00;
                    n_slave  = i_cmd.slave;
                    n_func   = i_cmd.func;
                    n_addr   = i_cmd.addr;
                    n_word   = i_cmd.word;
                end
                mrc_pkg::OP_END: begin
                    if (r_active) begin
                        n_active   = 1'b0;
                        res_valid  = 1'b1;
                        res_kind   = mrc_pkg::KIND_STATUS;
                        res_status = mrc_pkg::ST_SHORT;
                    end
                end
                mrc_pkg::OP_BYTE: begin
                    if (r_active) begin
                        n_count = r_count + 8'd1;
                        if (pos2 < {1'b0, r_len}) begin
                            n_crc  = mrc_pkg::crc16_byte(r_crc, b);
                            n_hbad = r_hbad || (want_en && (want != b));
                            if (is_read && (r_count >= 8'd3) && !n_hbad) begin
                                if (is_coil) begin
                                    res_valid = 1'b1;
                                    res_word  = {8'h00, b};
                                end else if (r_count[0]) begin
                                    n_held = b;
                                end else begin
                                    res_valid = 1'b1;
                                    res_word  = {r_held, b};
                                end
                            end
                        end else if (pos2 == {1'b0, r_len}) begin
                            // CRC low byte
                            n_held = b;
                        end else begin
                            n_active  = 1'b0;
                            res_valid = 1'b1;
                            res_kind  = mrc_pkg::KIND_STATUS;
                            if (is_single) begin
                                res_status = (r_hbad || crc_bad) ? mrc_pkg::ST_CRC_FAIL
                                                                 : mrc_pkg::ST_OK;
                            end else if (r_hbad) begin
                                res_status = mrc_pkg::ST_HEADER;
                            end else begin
                                res_status = crc_bad ? mrc_pkg::ST_CRC_FAIL : mrc_pkg::ST_OK;
                            end
                        end
                    end
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_len       <= 8'd0;
            r_count     <= 8'd0;
            r_crc       <= mrc_pkg::CRC_INIT;
            r_hbad      <= 1'b0;
            r_held      <= 8'h00;
            r_slave     <= 8'h00;
            r_func      <= 8'h00;
            r_addr      <= 16'h0000;
            r_word      <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_len       <= n_len;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_hbad      <= n_hbad;
            r_held      <= n_held;
            r_slave     <= n_slave;
            r_func      <= n_func;
            r_addr      <= n_addr;
            r_word      <= n_word;
            r_out_valid <= res_valid || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_kind   <= res_kind;
            r_out_word   <= res_word;
            r_out_status <= res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_word   = r_out_word;
    assign o_out_status = r_out_status;
    assign o_stat.active = r_active;
    assign o_stat.pop    = pop;

endmodule

// ----- rtl/core/modbus_rtu_response_checker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_top
// Checks a Modbus RTU slave reply byte by byte against the armed request.
// ----------------------------------------------------------------------------
// Arm with tuser = 0 (slave, function, address, quantity or value), feed each
// received byte with tuser = 1, and signal end of wait with tuser = 2. Read
// payload comes out as it arrives (coil bytes, or register words high byte
// first, tuser = 0); one status result (tuser = 1) follows at full length or
// end of wait, and a rejected arm gives a rejected status. The block takes one
// item per clock while the queue is not full; the back end does the per-byte
// CRC-16 update and header compare as each byte is popped. Items pass a
// two-entry queue and the output register before their results leave.
`include "modbus_rtu_response_checker_top_defines.svh"

module modbus_rtu_response_checker_top #(
    parameter int MAX_FRAME = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] slave_address, [15:8] function_code, [31:16] start_address,
    // [47:32] count_or_value, [55:48] data_byte
    input  logic [55:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] data_word, [18:16] status, [23:19] zero
    output logic [23:0] m_axis_tdata,
    // [0] kind
    output logic        m_axis_tuser
);

    mrc_pkg::t_cmd        f_cmd;
    logic                 f_cmd_valid;
    mrc_pkg::t_cmd        q_data;
    logic                 q_valid;
    mrc_pkg::t_queue_stat q_stat;
    mrc_pkg::t_back_stat  b_stat;
    logic                 push;
    logic [15:0]          out_word;
    logic [2:0]           out_status;
    logic                 pop_reject;
    logic                 out_reject;
    logic                 out_data;

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && s_axis_tready && f_cmd_valid;

    mrc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_mode           (s_axis_tuser),
        .i_slave_address  (s_axis_tdata[7:0]),
        .i_function_code  (s_axis_tdata[15:8]),
        .i_start_address  (s_axis_tdata[31:16]),
        .i_count_or_value (s_axis_tdata[47:32]),
        .i_data_byte      (s_axis_tdata[55:48]),
        .o_cmd_valid      (f_cmd_valid),
        .o_cmd            (f_cmd)
    );

    mrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_cmd),
        .i_pop   (b_stat.pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_stat  (q_stat)
    );

    mrc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_kind   (m_axis_tuser),
        .o_out_word   (out_word),
        .o_out_status (out_status),
        .o_stat       (b_stat)
    );

    assign m_axis_tdata = {5'b00000, out_status, out_word};

    assign pop_reject = b_stat.pop && (q_data.op == mrc_pkg::OP_REJECT);
    assign out_reject = m_axis_tvalid && (m_axis_tuser == mrc_pkg::KIND_STATUS)
                        && (out_status == mrc_pkg::ST_REJECTED);
    assign out_data   = m_axis_tvalid && (m_axis_tuser == mrc_pkg::KIND_DATA);

    // a rejected arm answers with a rejected status on the next cycle
    `MRC_ASSERT_NEXT(a_reject_status, i_clk, i_rst_n, pop_reject, out_reject)
    // and leaves the checker idle
    `MRC_ASSERT_NEXT(a_reject_idle, i_clk, i_rst_n, pop_reject, !b_stat.active)
    // payload results always carry an ok status field
    `MRC_ASSERT_IMP(a_data_status_zero, i_clk, i_rst_n, out_data, out_status == mrc_pkg::ST_OK)
    // back never pops an empty queue
    `MRC_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, b_stat.pop, q_stat.count != '0)

endmodule
